// ===== rtl/core/h263_picture_header_parser_assert.svh =====
// Assertion macros for the picture header parser.
// Both sample on clk and are disabled while arst_n is low.
`ifndef H263_PICTURE_HEADER_PARSER_ASSERT_SVH
`define H263_PICTURE_HEADER_PARSER_ASSERT_SVH

// Whenever cond holds, check must hold in the same cycle.
`define H263PH_ASSERT_SAME(lbl, cond, check) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (check)) \
		else $error("h263 picture header parser: assertion failed");

// Whenever cond holds, check must hold in the next cycle.
`define H263PH_ASSERT_NEXT(lbl, cond, check) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (check)) \
		else $error("h263 picture header parser: assertion failed");

`endif

// ===== rtl/core/h263ph_pkg.sv =====
package h263ph_pkg;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'd0,
		PH_PSC   = 5'd1,
		PH_TR    = 5'd2,
		PH_PT1   = 5'd3,
		PH_PT2   = 5'd4,
		PH_PT3   = 5'd5,
		PH_PT4   = 5'd6,
		PH_PT6   = 5'd7,
		PH_FMT   = 5'd8,
		PH_INTRA = 5'd9,
		PH_UFEP  = 5'd10,
		PH_EFMT  = 5'd11,
		PH_PCF   = 5'd12,
		PH_UMV   = 5'd13,
		PH_SAC   = 5'd14,
		PH_AP    = 5'd15,
		PH_AIC   = 5'd16,
		PH_RPS   = 5'd17,
		PH_MQ    = 5'd18,
		PH_RSV4  = 5'd19,
		PH_MPT   = 5'd20,
		PH_RPR   = 5'd21,
		PH_RRU   = 5'd22,
		PH_RTYPE = 5'd23,
		PH_RSV3  = 5'd24,
		PH_CPM   = 5'd25,
		PH_PAR   = 5'd26,
		PH_EPAR  = 5'd27,
		PH_PWI   = 5'd28,
		PH_MARK  = 5'd29,
		PH_PHI   = 5'd30
	} phase_t;

	// Result codes; ST_MORE means the field was fine and parsing goes on.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_PSC   = 3'd1;
	localparam logic [2:0] ST_BAD_BIT  = 3'd2;
	localparam logic [2:0] ST_BAD_FMT  = 3'd3;
	localparam logic [2:0] ST_BAD_TYPE = 3'd4;
	localparam logic [2:0] ST_MORE     = 3'd5;

	localparam logic [21:0] PSC_CODE = 22'h000020;

	typedef struct packed {
		logic [21:0] win;
		logic [4:0]  cnt;
		phase_t      phase;
		logic [2:0]  ufep;
		logic        cff;
		logic        intra;
		logic [11:0] pdw;
		logic [11:0] hw;
		logic [11:0] hh;
		logic [11:0] hdw;
		logic [10:0] hdh;
		logic        done;
		logic [2:0]  stat;
	} ph_state_t;

	function automatic logic [4:0] field_len(phase_t p);
		logic [4:0] n;
		case (p)
			PH_PSC:  n = 5'd22;
			PH_TR:   n = 5'd8;
			PH_FMT, PH_UFEP, PH_EFMT, PH_AIC, PH_RPS, PH_MPT, PH_RSV3: n = 5'd3;
			PH_RSV4, PH_PAR: n = 5'd4;
			PH_EPAR: n = 5'd16;
			PH_PWI, PH_PHI: n = 5'd9;
			PH_IDLE: n = 5'd0;
			default: n = 5'd1;
		endcase
		return n;
	endfunction

	function automatic logic [11:0] std_w(logic [2:0] f);
		logic [11:0] w;
		case (f)
			3'd1: w = 12'd128;
			3'd2: w = 12'd176;
			3'd3: w = 12'd352;
			3'd4: w = 12'd704;
			3'd5: w = 12'd1408;
			default: w = 12'd0;
		endcase
		return w;
	endfunction

	function automatic logic [10:0] std_h(logic [2:0] f);
		logic [10:0] h;
		case (f)
			3'd1: h = 11'd96;
			3'd2: h = 11'd144;
			3'd3: h = 11'd288;
			3'd4: h = 11'd576;
			3'd5: h = 11'd1152;
			default: h = 11'd0;
		endcase
		return h;
	endfunction

endpackage

// ===== rtl/core/h263_picture_header_parser.sv =====
// H.263 picture header parser. Bytes of the coded stream arrive MSB first,
// one per request; a request with picture_start set restarts the parse at
// the first bit of its byte. The parser checks the picture start code, skips
// the temporal reference, checks PTYPE, and follows the PLUSPTYPE path with
// a custom picture format when the source format is 7. Exactly one result
// request is sent per header: on success, or at the first bit that fails,
// after which bytes are dropped until the next picture_start. Sizes that a
// header does not set keep the values from earlier headers. The block takes
// one byte per cycle: a byte sits in an input register, all eight bit steps
// of the parse run combinationally from there, and the result is registered
// in an output register when the byte leaves the input register. A stalled
// result holds up the input only while a byte waits in the input register
// and the output register is still full.
module h263_picture_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	input  logic        picture_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        header_ok,
	output logic [2:0]  status,
	output logic [11:0] frame_width,
	output logic [11:0] frame_height,
	output logic [11:0] visible_width,
	output logic [10:0] visible_height,
	output logic        intra_picture
);
	import h263ph_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;
	ph_state_t   st_q;
	ph_state_t   chain [9];
	logic        out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Start of this byte's parse: the per-byte result flag is cleared, and a
	// picture start restarts the header fields but keeps the held sizes.
	always_comb begin
		chain[0]      = st_q;
		chain[0].done = 1'b0;
		chain[0].stat = ST_OK;
		if (start_s1) begin
			chain[0].win   = '0;
			chain[0].cnt   = '0;
			chain[0].phase = PH_PSC;
			chain[0].ufep  = '0;
			chain[0].cff   = 1'b0;
			chain[0].intra = 1'b0;
			chain[0].pdw   = '0;
		end
	end

	for (genvar g = 0; g < 8; g++) begin : g_bit
		h263ph_step u_step (
			.cur    (chain[g]),
			.bit_in (byte_s1[7-g]),
			.nxt    (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			start_s1    <= 1'b0;
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
				start_s1 <= picture_start;
			end
			if (advance && chain[8].done) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (advance) st_q <= chain[8];
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) byte_s1 <= stream_byte;
		if (advance && chain[8].done) begin
			header_ok      <= (chain[8].stat == ST_OK);
			status         <= chain[8].stat;
			frame_width    <= chain[8].hw;
			frame_height   <= chain[8].hh;
			visible_width  <= chain[8].hdw;
			visible_height <= chain[8].hdh;
			intra_picture  <= (chain[8].stat == ST_OK) && chain[8].intra;
		end
	end

	assign out_valid = out_valid_q;

`include "h263_picture_header_parser_assert.svh"

	`H263PH_ASSERT_SAME(a_ok_matches_status, out_valid, header_ok == (status == ST_OK))
	`H263PH_ASSERT_SAME(a_status_range, out_valid, status <= ST_BAD_TYPE)
	`H263PH_ASSERT_SAME(a_stall_cause, !in_ready, valid_s1 && out_valid_q && !out_ready)
	`H263PH_ASSERT_NEXT(a_idle_after_result, advance && chain[8].done, st_q.phase == PH_IDLE)

endmodule

// ===== rtl/core/h263ph_step.sv =====
// One bit of the header parse: shifts the bit in and, when a field is
// complete, checks it and moves on to the next field.
module h263ph_step (
	input  h263ph_pkg::ph_state_t cur,
	input  logic                  bit_in,
	output h263ph_pkg::ph_state_t nxt
);
	import h263ph_pkg::*;

	logic [21:0] win;
	logic [4:0]  cnt;
	logic [2:0]  r;
	phase_t      nph;
	logic [9:0]  pwi_p1;
	logic [10:0] hdh_new;

	always_comb begin
		win     = {cur.win[20:0], bit_in};
		cnt     = cur.cnt + 5'd1;
		pwi_p1  = {1'b0, win[8:0]} + 10'd1;
		hdh_new = {win[8:0], 2'b00};
		r       = ST_MORE;
		nph     = (cur.phase == PH_PHI) ? PH_IDLE : phase_t'(cur.phase + 5'd1);
		nxt     = cur;
		if (!cur.done) begin
			if (cur.phase == PH_IDLE || cur.phase > PH_PHI) begin
				nxt.phase = PH_IDLE;
			end else if (cnt < field_len(cur.phase)) begin
				nxt.win = win;
				nxt.cnt = cnt;
			end else begin
				nxt.win = '0;
				nxt.cnt = '0;
				unique case (cur.phase)
					PH_PSC: if (win != PSC_CODE) r = ST_NO_PSC;
					PH_TR, PH_PCF, PH_AIC, PH_MQ, PH_RTYPE, PH_EPAR: ;
					PH_PT1: if (win[0] == 1'b0) r = ST_BAD_BIT;
					PH_PT2, PH_PT3, PH_PT4, PH_PT6, PH_UMV, PH_SAC, PH_AP, PH_RPS,
					PH_RPR, PH_RRU: begin
						if (win[2:0] != 3'd0) r = ST_BAD_BIT;
					end
					PH_FMT: begin
						if (win[2:0] == 3'd7) begin
							nph = PH_UFEP;
						end else if (win[2:0] == 3'd0 || win[2:0] == 3'd6) begin
							r = ST_BAD_FMT;
						end else begin
							nxt.hw  = std_w(win[2:0]);
							nxt.hh  = {1'b0, std_h(win[2:0])};
							nxt.hdw = std_w(win[2:0]);
							nxt.hdh = std_h(win[2:0]);
							nph     = PH_INTRA;
						end
					end
					PH_INTRA: begin
						nxt.intra = ~win[0];
						r         = ST_OK;
					end
					PH_UFEP: begin
						nxt.ufep = win[2:0];
						if (win[2:0] == 3'd1) nph = PH_EFMT;
						else if (win[2:0] == 3'd0) nph = PH_MPT;
						else r = ST_BAD_TYPE;
					end
					PH_EFMT: begin
						if (win[2:0] == 3'd6) begin
							nxt.cff = 1'b1;
						end else if (win[2:0] == 3'd0 || win[2:0] == 3'd7) begin
							r = ST_BAD_FMT;
						end else begin
							nxt.hw  = std_w(win[2:0]);
							nxt.hh  = {1'b0, std_h(win[2:0])};
							nxt.hdw = std_w(win[2:0]);
							nxt.hdh = std_h(win[2:0]);
						end
					end
					PH_RSV4: if (win[3:0] != 4'd8) r = ST_BAD_TYPE;
					PH_MPT: begin
						if (win[2:1] != 2'd0) r = ST_BAD_TYPE;
						else nxt.intra = ~win[0];
					end
					PH_RSV3: if (win[2:0] != 3'd1) r = ST_BAD_TYPE;
					PH_CPM: begin
						if (win[0]) r = ST_BAD_BIT;
						else if (cur.cff && cur.ufep == 3'd1) nph = PH_PAR;
						else r = ST_OK;
					end
					PH_PAR: begin
						if (win[3:0] == 4'd0) r = ST_BAD_FMT;
						else if (win[3:0] == 4'hF) nph = PH_EPAR;
						else nph = PH_PWI;
					end
					PH_PWI: nxt.pdw = {pwi_p1, 2'b00};
					PH_MARK: if (!win[0]) r = ST_BAD_BIT;
					PH_PHI: begin
						if (win[8:0] == 9'd0) begin
							r = ST_BAD_FMT;
						end else begin
							nxt.hdw = cur.pdw;
							nxt.hw  = (cur.pdw + 12'd15) & 12'hFF0;
							nxt.hdh = hdh_new;
							nxt.hh  = ({1'b0, hdh_new} + 12'd15) & 12'hFF0;
							r       = ST_OK;
						end
					end
					default: r = ST_BAD_TYPE;
				endcase
				if (r == ST_MORE) begin
					nxt.phase = nph;
				end else begin
					nxt.phase = PH_IDLE;
					nxt.done  = 1'b1;
					nxt.stat  = r;
				end
			end
		end
	end

endmodule
